[rtl/bls_pkg.sv]
// Shared constants, types and codes of the band level smoother.
package bls_pkg;

    localparam int BAND_COUNT  = 16;
    localparam int BAND_IDX_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    localparam int BAND_W      = 4;
    localparam int MAG_W       = 32;
    localparam int DIV_W       = 16;
    localparam int WGT_W       = 7;
    localparam int LVL_W       = 8;

    // Largest weighted sum is 255 * 100, which needs 15 bits.
    localparam int SUM_W       = 15;

    // floor(x / 100) equals (x * 5243) >> 19 for every x below 2**15.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;

    localparam logic [WGT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [DIV_W-1:0] DIVISOR_RST = 16'd1000;
    localparam logic [WGT_W-1:0] BLEND_RST   = 7'd50;
    localparam logic [LVL_W-1:0] COLUMN_RST  = 8'd16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVISOR = 2'd0,
        CFG_BLEND   = 2'd1,
        CFG_COLUMN  = 2'd2
    } cfg_index_t;

    // Input word: band, then raw magnitude, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    // Result word: band, level, peak, padded to whole bytes.
    localparam int M_TDATA_W = 24;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_DECAY  = 1'b1;

    typedef struct packed {
        logic start;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

[rtl/bls_divider.sv]
// Bit-serial restoring divider that yields one quotient bit per cycle.
module bls_divider
    import bls_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  unit_cmd_t        cmd,
    input  logic [MAG_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output unit_sts_t        sts,
    output logic [MAG_W-1:0] quotient
);

    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    logic [MAG_W-1:0] qr_reg, qr_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // The dividend shifts out at the top while quotient bits shift in below.
    // A zero divisor always fits, so the quotient comes out as all ones.
    assign trial = {rem_reg, qr_reg[MAG_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            qr_next   = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            qr_next  = {qr_reg[MAG_W-2:0], fits};
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = qr_reg;

endmodule

[rtl/bls_blend.sv]
// Serial shift-add blend of old and new height, then a scale by one hundredth.
module bls_blend
    import bls_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  unit_cmd_t        cmd,
    input  logic [LVL_W-1:0] old_level,
    input  logic [LVL_W-1:0] new_height,
    input  logic [WGT_W-1:0] weight,
    output unit_sts_t        sts,
    output logic [LVL_W-1:0] level
);

    localparam int CNT_W = $clog2(WGT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WGT_W - 1);
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [WGT_W-1:0] wn_reg, wn_next;
    logic [WGT_W-1:0] wo_reg, wo_next;
    logic [SUM_W-1:0] hn_reg, hn_next;
    logic [SUM_W-1:0] ol_reg, ol_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             scale_reg, scale_next;
    logic             done_reg, done_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(acc_reg) * PROD_W'(RECIP_MUL);

    // One weight bit of each operand per cycle, least significant first.
    always_comb begin
        wn_next    = wn_reg;
        wo_next    = wo_reg;
        hn_next    = hn_reg;
        ol_next    = ol_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        scale_next = 1'b0;
        done_next  = 1'b0;
        lvl_next   = lvl_reg;
        if (cmd.start) begin
            wn_next   = weight;
            wo_next   = PCT_FULL - weight;
            hn_next   = SUM_W'(new_height);
            ol_next   = SUM_W'(old_level);
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + (wo_reg[0] ? ol_reg : '0) + (wn_reg[0] ? hn_reg : '0);
            wn_next  = wn_reg >> 1;
            wo_next  = wo_reg >> 1;
            hn_next  = hn_reg << 1;
            ol_next  = ol_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next  = 1'b0;
                scale_next = 1'b1;
            end
        end else if (scale_reg) begin
            lvl_next  = prod[RECIP_SHIFT +: LVL_W];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        wn_reg  <= wn_next;
        wo_reg  <= wo_next;
        hn_reg  <= hn_next;
        ol_reg  <= ol_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        lvl_reg <= lvl_next;
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            scale_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            scale_reg <= scale_next;
            done_reg  <= done_next;
        end
    end

    assign sts.busy = busy_reg | scale_reg;
    assign sts.done = done_reg;
    assign level    = lvl_reg;

endmodule

[rtl/band_level_smoother_peak_hold_top.sv]
// Top level of the band level smoother with peak hold and decay.
// A sample word passes through the serial divider, the serial blend, a scaling
// step and the state update. A decay word, or a word for a band outside the table,
// goes straight to the finishing step. One word is in work at a time; the input
// is not ready again until its result has been handed to the output register,
// which waits while an earlier result is still held there. Synchronous active-low reset.
module band_level_smoother_peak_hold_top
    import bls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // band[3:0], raw_magnitude[35:4], zero pad
    input  logic                  s_tuser,   // func[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // band_out[3:0], level[11:4], peak[19:12], pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_BLEND,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;

    logic [DIV_W-1:0]      divisor_reg;
    logic [WGT_W-1:0]      blend_reg;
    logic [LVL_W-1:0]      column_reg;

    logic [LVL_W-1:0]      level_mem_reg [BAND_COUNT];
    logic [LVL_W-1:0]      peak_mem_reg  [BAND_COUNT];

    logic [BAND_W-1:0]     band_reg, band_next;
    logic                  func_reg, func_next;
    logic                  range_reg, range_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [BAND_W-1:0]     s_band;
    logic [MAG_W-1:0]      s_mag;
    logic                  s_accept;
    logic                  s_range;

    logic [BAND_IDX_W-1:0] idx;
    logic [LVL_W-1:0]      old_level;
    logic [LVL_W-1:0]      old_peak;
    logic [WGT_W-1:0]      weight;
    logic [MAG_W-1:0]      quotient;
    logic [LVL_W-1:0]      height;
    logic [LVL_W-1:0]      blend_level;
    logic [LVL_W-1:0]      new_level;
    logic [LVL_W-1:0]      new_peak;
    logic                  commit;

    unit_cmd_t             div_cmd;
    unit_sts_t             div_sts;
    unit_cmd_t             blend_cmd;
    unit_sts_t             blend_sts;

    assign s_band   = s_tdata[BAND_W-1:0];
    assign s_mag    = s_tdata[BAND_W +: MAG_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_range  = 32'(s_band) < 32'(BAND_COUNT);

    assign cfg_ready = 1'b1;

    assign idx       = band_reg[BAND_IDX_W-1:0];
    assign old_level = level_mem_reg[idx];
    assign old_peak  = peak_mem_reg[idx];
    assign weight    = (blend_reg > PCT_FULL) ? PCT_FULL : blend_reg;

    // Clamp the full quotient to the column height.
    assign height = ((quotient[MAG_W-1:LVL_W] != '0) || (quotient[LVL_W-1:0] > column_reg))
                    ? column_reg : quotient[LVL_W-1:0];

    assign div_cmd.start   = s_accept && s_range && (s_tuser == FUNC_SAMPLE);
    assign blend_cmd.start = div_sts.done;

    bls_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .dividend (s_mag),
        .divisor  (divisor_reg),
        .sts      (div_sts),
        .quotient (quotient)
    );

    bls_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (blend_cmd),
        .old_level  (old_level),
        .new_height (height),
        .weight     (weight),
        .sts        (blend_sts),
        .level      (blend_level)
    );

    // New level and peak of the band held in the work registers.
    always_comb begin
        new_level = old_level;
        new_peak  = old_peak;
        if (func_reg == FUNC_DECAY) begin
            if (old_peak != '0) begin
                new_peak = old_peak - 1'b1;
            end
        end else begin
            new_level = blend_level;
            if (blend_level > old_peak) begin
                new_peak = (blend_level > column_reg) ? column_reg : blend_level;
            end
        end
    end

    assign commit = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        band_next     = band_reg;
        func_next     = func_reg;
        range_next    = range_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    band_next  = s_band;
                    func_next  = s_tuser;
                    range_next = s_range;
                    state_next = div_cmd.start ? S_DIV : S_FINISH;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND: begin
                if (blend_sts.done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (commit) begin
                    m_tvalid_next = 1'b1;
                    if (range_reg) begin
                        m_tdata_next = M_TDATA_W'({new_peak, new_level, band_reg});
                    end else begin
                        m_tdata_next = M_TDATA_W'(band_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        band_reg    <= band_next;
        func_reg    <= func_next;
        range_reg   <= range_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            divisor_reg  <= DIVISOR_RST;
            blend_reg    <= BLEND_RST;
            column_reg   <= COLUMN_RST;
            for (int i = 0; i < BAND_COUNT; i++) begin
                level_mem_reg[i] <= '0;
                peak_mem_reg[i]  <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIVISOR: divisor_reg <= cfg_data[DIV_W-1:0];
                    CFG_BLEND:   blend_reg   <= cfg_data[WGT_W-1:0];
                    CFG_COLUMN:  column_reg  <= cfg_data[LVL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (commit && range_reg) begin
                level_mem_reg[idx] <= new_level;
                peak_mem_reg[idx]  <= new_peak;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide phase");

    a_blend_done_in_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        blend_sts.done |-> (state_reg == S_BLEND))
        else $error("blend finished outside the blend phase");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("result appeared without a finishing step");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_sts.busy && blend_sts.busy))
        else $error("divider and blend unit busy at once");
`endif

endmodule

[sim/tb_band_level_smoother_peak_hold_top.sv]
// Self-checking testbench of the band level smoother with peak hold and decay.
`timescale 1ns / 100ps

module tb_band_level_smoother_peak_hold_top;
    import bls_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 1800;
    localparam int PHASES       = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int SHOWN_ERRORS = 10;
    localparam int unsigned PERCENT = 100;
    // The index port has one code that maps to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [BAND_W-1:0] band;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  peak;
    } meter_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // band[3:0], raw_magnitude[35:4], zero pad
    logic                  s_tuser   = 1'b0;  // func[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;  // band_out[3:0], level[11:4], peak[19:12], pad
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the block's registers and band tables.
    logic [DIV_W-1:0] divisor_shadow = DIVISOR_RST;
    logic [WGT_W-1:0] blend_shadow   = BLEND_RST;
    logic [LVL_W-1:0] column_shadow  = COLUMN_RST;
    logic [LVL_W-1:0] level_mem [BAND_COUNT];
    logic [LVL_W-1:0] peak_mem  [BAND_COUNT];

    meter_word_t expected_meter_q [$];

    int cycle_count    = 0;
    int words_sent     = 0;
    int decays_sent    = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    int mismatch_count = 0;

    // Sender pacing.
    bit idle_on    = 1'b1;
    int burst_left = 0;

    // Receiver pacing.
    bit stall_on     = 1'b1;
    int stall_pct    = 30;
    int stall_left   = 0;
    int hold_request = 0;
    int hold_left    = 0;

    band_level_smoother_peak_hold_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     expected_meter_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Applies one word to the mirrored band tables and returns the result it yields.
    function automatic meter_word_t advance_meter(logic func, logic [BAND_W-1:0] band,
                                                  logic [MAG_W-1:0] mag);
        meter_word_t r;
        logic [MAG_W-1:0] height;
        int unsigned weight;
        int unsigned blended;
        r.band  = band;
        r.level = '0;
        r.peak  = '0;
        if (band < BAND_COUNT) begin
            if (func == FUNC_SAMPLE) begin
                weight = (blend_shadow > PCT_FULL) ? PERCENT : 32'(blend_shadow);
                height = (divisor_shadow == 0) ? '1 : mag / MAG_W'(divisor_shadow);
                if (height > MAG_W'(column_shadow))
                    height = MAG_W'(column_shadow);
                blended = (level_mem[band] * (PERCENT - weight) + height * weight) / PERCENT;
                level_mem[band] = blended[LVL_W-1:0];
                if (blended > peak_mem[band])
                    peak_mem[band] = (blended > column_shadow) ? column_shadow
                                                               : blended[LVL_W-1:0];
            end else if (peak_mem[band] != 0) begin
                peak_mem[band] = peak_mem[band] - 1'b1;
            end
            r.level = level_mem[band];
            r.peak  = peak_mem[band];
        end
        return r;
    endfunction

    function automatic void flag_mismatch(string what, logic [LVL_W-1:0] want_v,
                                          logic [LVL_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("Mismatch at result %0d: %s expected %0h, got %0h",
                     results_seen, what, want_v, got_v);
    endfunction

    // Result checker: each accepted word is compared with the oldest expectation.
    always @(posedge aclk) begin
        meter_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_meter_q.size() == 0) begin
                flag_mismatch("unexpected word, band", '0, LVL_W'(m_tdata[BAND_W-1:0]));
            end else begin
                want = expected_meter_q.pop_front();
                if (m_tdata[BAND_W-1:0] !== want.band)
                    flag_mismatch("band_out", LVL_W'(want.band), LVL_W'(m_tdata[BAND_W-1:0]));
                if (m_tdata[BAND_W +: LVL_W] !== want.level)
                    flag_mismatch("level", want.level, m_tdata[BAND_W +: LVL_W]);
                if (m_tdata[BAND_W+LVL_W +: LVL_W] !== want.peak)
                    flag_mismatch("peak", want.peak, m_tdata[BAND_W+LVL_W +: LVL_W]);
            end
        end
    end

    // Receiver: random stall runs, plus an occasional long hold-off on request.
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic func, input logic [BAND_W-1:0] band,
                             input logic [MAG_W-1:0] mag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (!idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(S_TDATA_W-BAND_W-MAG_W){1'b0}}, mag, band};
        do @(posedge aclk); while (!s_tready);
        expected_meter_q.push_back(advance_meter(func, band, mag));
        words_sent++;
        if (func == FUNC_DECAY)
            decays_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DIVISOR: divisor_shadow = value[DIV_W-1:0];
            CFG_BLEND:   blend_shadow   = value[WGT_W-1:0];
            CFG_COLUMN:  column_shadow  = value[LVL_W-1:0];
            default:     ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering words and waits until every expected result has been taken.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_meter_q.size() != 0) @(posedge aclk);
    endtask

    // Magnitudes are mostly scaled so that heights spread over the whole column.
    function automatic logic [MAG_W-1:0] pick_magnitude();
        longint unsigned m;
        case ($urandom_range(0, 9))
            0:       m = 0;
            1:       m = 64'hFFFF_FFFF;
            2, 3:    m = $urandom;
            default: begin
                m = longint'($urandom_range(0, column_shadow + 3)) * divisor_shadow;
                if (divisor_shadow > 1)
                    m += $urandom_range(0, divisor_shadow - 1);
            end
        endcase
        if (m > 64'hFFFF_FFFF)
            m = 64'hFFFF_FFFF;
        return m[MAG_W-1:0];
    endfunction

    task automatic send_random_word();
        logic func;
        func = ($urandom_range(0, 3) == 0) ? FUNC_DECAY : FUNC_SAMPLE;
        send_word(func, BAND_W'($urandom_range(0, BAND_COUNT - 1)), pick_magnitude());
    endtask

    task automatic test_reset_defaults();
        send_word(FUNC_SAMPLE, 4'd0, 32'd16000);
        send_word(FUNC_SAMPLE, 4'd0, 32'd16000);
        send_word(FUNC_SAMPLE, 4'd1, 32'd0);
        send_word(FUNC_DECAY,  4'd0, 32'd0);
    endtask

    task automatic test_field_extremes();
        send_word(FUNC_SAMPLE, 4'd15, 32'hFFFF_FFFF);
        send_word(FUNC_SAMPLE, 4'd10, 32'hAAAA_AAAA);
        send_word(FUNC_SAMPLE, 4'd5,  32'h5555_5555);
        send_word(FUNC_SAMPLE, 4'd0,  32'd0);
    endtask

    task automatic test_peak_decay();
        // An untouched band keeps its peak at zero under decay.
        send_word(FUNC_DECAY, 4'd2, 32'd0);
        send_word(FUNC_DECAY, 4'd2, 32'hFFFF_FFFF);
        send_word(FUNC_DECAY, 4'd15, 32'd0);
        send_word(FUNC_DECAY, 4'd15, 32'd0);
        send_word(FUNC_DECAY, 4'd1, 32'd0);
    endtask

    task automatic test_register_extremes();
        drain_results();
        // A zero divisor drives the height to the column top; blend above 100 saturates.
        write_reg(CFG_DIVISOR, 16'd0);
        write_reg(CFG_BLEND, 16'd127);
        write_reg(CFG_COLUMN, 16'd255);
        write_reg(CFG_SPARE, 16'hA5A5);
        send_word(FUNC_SAMPLE, 4'd4, 32'd0);
        drain_results();
        write_reg(CFG_DIVISOR, 16'd1);
        write_reg(CFG_BLEND, 16'd0);
        send_word(FUNC_SAMPLE, 4'd4, 32'd7);
        drain_results();
        // Lowering the column leaves the stored level alone but clamps a new peak.
        write_reg(CFG_COLUMN, 16'd10);
        send_word(FUNC_DECAY, 4'd4, 32'd0);
        send_word(FUNC_SAMPLE, 4'd4, 32'd0);
        drain_results();
        write_reg(CFG_COLUMN, 16'd0);
        write_reg(CFG_BLEND, 16'd100);
        write_reg(CFG_DIVISOR, 16'hFFFF);
        send_word(FUNC_SAMPLE, 4'd6, 32'hFFFF_FFFF);
        drain_results();
        write_reg(CFG_BLEND, 16'd101);
        send_word(FUNC_SAMPLE, 4'd4, 32'd5);
        drain_results();
        write_reg(CFG_COLUMN, 16'd1);
        write_reg(CFG_BLEND, 16'd100);
        write_reg(CFG_DIVISOR, 16'd1);
        send_word(FUNC_SAMPLE, 4'd7, 32'd3);
        drain_results();
    endtask

    task automatic test_output_hold_off();
        drain_results();
        write_reg(CFG_DIVISOR, 16'd100);
        write_reg(CFG_BLEND, 16'd60);
        write_reg(CFG_COLUMN, 16'd200);
        idle_on  = 1'b0;
        stall_on = 1'b0;
        // The sender keeps offering words while the receiver holds off.
        hold_request = HOLD_CYCLES;
        repeat (24) send_random_word();
        drain_results();
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] div_v;
        logic [CFG_DATA_W-1:0] blend_v;
        logic [CFG_DATA_W-1:0] col_v;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    div_v   = 16'd0;
                    blend_v = CFG_DATA_W'($urandom_range(0, 100));
                    col_v   = CFG_DATA_W'($urandom_range(1, 32));
                end
                1: begin
                    div_v   = 16'd1;
                    blend_v = 16'd100;
                    col_v   = 16'd255;
                end
                2: begin
                    div_v   = 16'hFFFF;
                    blend_v = 16'd0;
                    col_v   = 16'd1;
                end
                3: begin
                    div_v   = CFG_DATA_W'($urandom_range(1, 500));
                    blend_v = CFG_DATA_W'($urandom_range(101, 127));
                    col_v   = 16'd0;
                end
                default: begin
                    div_v = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 65535)
                                                             : $urandom_range(1, 2000));
                    // Bits above the register width are sent at random.
                    blend_v = CFG_DATA_W'(($urandom & 16'hFF80) | $urandom_range(0, 127));
                    col_v   = CFG_DATA_W'(($urandom & 16'hFF00) | $urandom_range(1, 255));
                end
            endcase
            write_reg(CFG_DIVISOR, div_v);
            write_reg(CFG_BLEND, blend_v);
            write_reg(CFG_COLUMN, col_v);
            idle_on   = (phase % 3 != 0);
            stall_on  = (phase % 3 != 0);
            stall_pct = $urandom_range(10, 60);
            repeat (RANDOM_WORDS / PHASES) send_random_word();
        end
        drain_results();
    endtask

    initial begin
        for (int b = 0; b < BAND_COUNT; b++) begin
            level_mem[b] = '0;
            peak_mem[b]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_peak_decay();
        test_register_extremes();
        test_output_hold_off();
        test_random_phases();

        drain_results();
        repeat (60) @(posedge aclk);
        if (expected_meter_q.size() != 0) begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_meter_q.size());
        end
        $display("Sent %0d words (%0d decay ticks) over %0d register writes,", words_sent,
                 decays_sent, cfg_writes);
        $display("checked %0d results with one long output hold-off; %0d mismatches.",
                 results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bls_pkg.sv
rtl/bls_divider.sv
rtl/bls_blend.sv
rtl/band_level_smoother_peak_hold_top.sv
sim/tb_band_level_smoother_peak_hold_top.sv
